@@ rtl/les_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_pkg: shared types and constants of the largest empty square finder
// Holds the beat formats of the input cell and of the result square.
// ----------------------------------------------------------------------------
package les_pkg;

	localparam int CELL_W = 8;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 10;
	localparam int SIDE_W = 11;

	localparam logic [CELL_W-1:0] EMPTY_CHAR_RESET = 8'd46;

	typedef struct packed {
		logic              end_of_map;
		logic              end_of_row;
		logic [CELL_W-1:0] cell_byte;
	} cell_t;

	typedef struct packed {
		logic              overflow;
		logic [SIDE_W-1:0] side;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} result_t;

endpackage

@@ rtl/les_row_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_row_buf: one-row buffer of square sides
// Single write port and one registered read port; a write to the address
// being read is passed straight to the read data.
// ----------------------------------------------------------------------------
module les_row_buf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/les_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_core: per-cell square update and best square tracking
// Forms 1 + min(left, up, up-left) for each empty cell, keeps the first
// strictly larger square and presents the result on the end-of-map beat.
// ----------------------------------------------------------------------------
module les_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [les_pkg::CELL_W-1:0]        empty_char,
	input  logic                              adv,
	input  les_pkg::cell_t                    item,
	output les_pkg::result_t                  res
);

	import les_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	logic [CW-1:0] col_q;
	logic [CW-1:0] prev_width_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] diag_q;
	logic [CW-1:0] best_col_q;
	logic [CW-1:0] best_side_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] best_row_q;
	logic          overflow_q;

	logic          col_ok;
	logic          row_ok;
	logic          have_up;
	logic          is_empty;
	logic          end_line;
	logic          better;
	logic [CW-1:0] up_run;
	logic [CW-1:0] left_run;
	logic [CW-1:0] diag_run;
	logic [CW-1:0] min_lu;
	logic [CW-1:0] min_all;
	logic [CW-1:0] side;
	logic [CW-1:0] col_inc;
	logic [CW-1:0] col_after;
	logic [CW-1:0] nb_col;
	logic [CW-1:0] nb_side;
	logic [RW-1:0] nb_row;
	logic          nb_overflow;
	logic [CW-1:0] rd_data;
	logic [AW-1:0] rd_addr;
	logic          wr_en;

	assign col_ok   = col_q < CW'(MAX_WIDTH);
	assign row_ok   = row_q < RW'(MAX_HEIGHT);
	assign have_up  = (row_q != '0) && (col_q < prev_width_q);
	assign up_run   = have_up ? rd_data : '0;
	assign left_run = (col_q != '0) ? left_q : '0;
	assign diag_run = (col_q != '0) ? diag_q : '0;
	assign min_lu   = (left_run < up_run) ? left_run : up_run;
	assign min_all  = (min_lu < diag_run) ? min_lu : diag_run;
	assign is_empty = (item.cell_byte == empty_char) && row_ok && col_ok;
	assign side     = is_empty ? min_all + CW'(1) : '0;
	assign better   = side > best_side_q;
	assign end_line = item.end_of_row || item.end_of_map;

	assign col_inc   = col_ok ? col_q + CW'(1) : col_q;
	assign col_after = end_line ? '0 : col_inc;

	assign nb_side     = better ? side : best_side_q;
	assign nb_col      = better ? CW'(col_q + CW'(1) - side) : best_col_q;
	assign nb_row      = better ? RW'(row_q + RW'(1) - side) : best_row_q;
	assign nb_overflow = overflow_q || !col_ok || !row_ok;

	assign res.col      = COL_W'(nb_col);
	assign res.row      = ROW_W'(nb_row);
	assign res.side     = SIDE_W'(nb_side);
	assign res.overflow = nb_overflow;

	// The read always points at the column of the next cell to be processed.
	assign rd_addr = adv ? col_after[AW-1:0] : col_q[AW-1:0];
	assign wr_en   = adv && col_ok;

	les_row_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW),
		.DW    (CW)
	) u_row_buf (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (col_q[AW-1:0]),
		.wr_data (side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			prev_width_q <= '0;
			left_q       <= '0;
			diag_q       <= '0;
			best_col_q   <= '0;
			best_side_q  <= '0;
			row_q        <= '0;
			best_row_q   <= '0;
			overflow_q   <= 1'b0;
		end else if (adv) begin
			if (item.end_of_map) begin
				col_q        <= '0;
				prev_width_q <= '0;
				left_q       <= '0;
				diag_q       <= '0;
				best_col_q   <= '0;
				best_side_q  <= '0;
				row_q        <= '0;
				best_row_q   <= '0;
				overflow_q   <= 1'b0;
			end else begin
				best_col_q  <= nb_col;
				best_row_q  <= nb_row;
				best_side_q <= nb_side;
				overflow_q  <= nb_overflow;
				col_q       <= col_after;
				if (item.end_of_row) begin
					prev_width_q <= col_inc;
					left_q       <= '0;
					diag_q       <= '0;
					if (row_ok) begin
						row_q <= row_q + RW'(1);
					end
				end else if (col_ok) begin
					left_q <= side;
					diag_q <= up_run;
				end
			end
		end
	end

endmodule

@@ rtl/largest_empty_square.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_empty_square: streaming finder of the largest empty square in a map
// Cells enter in row-major order; one result beat leaves per map.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_*      in   tdata: cell[7:0]; tuser: end_of_row; tlast: end_of_map
// m_*      out  tdata: square_col[9:0], square_row[19:10], square_side[30:20]
//               tuser: overflow
// cfg_*    in   cfg_wdata: empty_char[7:0], written when cfg_we is high
//
// One cell beat is taken every cycle unless a waiting result holds an end-of-map
// beat; each beat is folded into the map state as it leaves the input register.
// The result beat enters the output register at the edge where the end-of-map
// beat leaves the input register.
// The row buffer is read one cell ahead, so its registered port sets no stall.
// A result waiting on m_tready stalls the next end-of-map beat and the beats behind it.
// Reset needs no clearing pass; the empty character resets to 46.
// ----------------------------------------------------------------------------
module largest_empty_square #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // cell[7:0]
	input  logic        s_tuser,   // end_of_row
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // square_col, square_row, square_side, zero pad
	output logic        m_tuser,   // overflow
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	import les_pkg::*;

	logic [CELL_W-1:0] empty_char_q;
	cell_t             item_s1;
	logic              valid_s1;
	logic              adv;
	result_t           res;
	result_t           res_q;
	logic              out_valid_q;

	assign adv      = valid_s1 && (!item_s1.end_of_map || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_char_q <= EMPTY_CHAR_RESET;
		end else if (cfg_we) begin
			empty_char_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= '{end_of_map: s_tlast, end_of_row: s_tuser, cell_byte: s_tdata};
		end
	end

	les_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty_char (empty_char_q),
		.adv        (adv),
		.item       (item_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && item_s1.end_of_map) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.end_of_map) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.side, res_q.row, res_q.col};
	assign m_tuser  = res_q.overflow;

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input register empty but beat refused");

	a_stalled_item_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("stalled input register lost its beat");

	a_result_from_map_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(adv && item_s1.end_of_map))
		else $error("result beat without an end-of-map beat");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !(adv && item_s1.end_of_map))
		else $error("pending result overwritten");

endmodule

@@ sim/les_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_checker: scoreboard for the largest empty square finder
// Follows every accepted cell beat with its own square search, queues the
// square expected at each end of map and compares each result beat with it.
// ----------------------------------------------------------------------------
module les_checker #(
	parameter int MAX_W = 1024,
	parameter int MAX_H = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output int          fail_count,
	output int          pending,
	output int          squares_checked
);

	import les_pkg::*;

	logic [CELL_W-1:0] empty_char_q;
	logic [SIDE_W-1:0] up_runs [MAX_W];
	logic [SIDE_W-1:0] left_side;
	logic [SIDE_W-1:0] diag_side;
	logic [SIDE_W-1:0] col_idx;
	logic [SIDE_W-1:0] row_idx;
	logic [SIDE_W-1:0] above_width;
	logic [SIDE_W-1:0] best_side;
	logic [COL_W-1:0]  best_col;
	logic [ROW_W-1:0]  best_row;
	logic              ovf_seen;
	result_t           expected_squares [$];
	int                errors = 0;
	int                checked = 0;

	task automatic report_mismatch(input string what);
		if (errors < 30)
			$display("[%0t] mismatch: %s", $time, what);
		errors++;
	endtask

	task automatic clear_scan();
		left_side   = '0;
		diag_side   = '0;
		col_idx     = '0;
		row_idx     = '0;
		above_width = '0;
		best_side   = '0;
		best_col    = '0;
		best_row    = '0;
		ovf_seen    = 1'b0;
	endtask

	task automatic fold_cell(input logic [CELL_W-1:0] cell_byte, input logic eor,
		input logic eom);
		logic [SIDE_W-1:0] c;
		logic [SIDE_W-1:0] up;
		logic [SIDE_W-1:0] lft;
		logic [SIDE_W-1:0] dg;
		logic [SIDE_W-1:0] m;
		logic [SIDE_W-1:0] side;
		c    = col_idx;
		side = '0;
		if (c >= MAX_W || row_idx >= MAX_H)
			ovf_seen = 1'b1;
		if (c < MAX_W) begin
			up  = (row_idx > 0 && c < above_width) ? up_runs[c] : '0;
			lft = (c > 0) ? left_side : '0;
			dg  = (c > 0) ? diag_side : '0;
			if (cell_byte == empty_char_q && row_idx < MAX_H) begin
				m = (lft < up) ? lft : up;
				if (dg < m)
					m = dg;
				side = m + 1'b1;
				if (side > best_side) begin
					best_side = side;
					best_col  = COL_W'(c + 1'b1 - side);
					best_row  = ROW_W'(row_idx + 1'b1 - side);
				end
			end
			diag_side  = up;
			left_side  = side;
			up_runs[c] = side;
			col_idx    = c + 1'b1;
		end
		if (eor || eom) begin
			above_width = col_idx;
			col_idx     = '0;
			left_side   = '0;
			diag_side   = '0;
			if (row_idx < MAX_H)
				row_idx = row_idx + 1'b1;
		end
		if (eom) begin
			expected_squares.push_back('{overflow: ovf_seen, side: best_side,
				row: best_row, col: best_col});
			clear_scan();
		end
	endtask

	task automatic compare_result();
		result_t got;
		result_t want;
		got = result_t'({m_tuser, m_tdata[30:0]});
		if (expected_squares.size() == 0) begin
			report_mismatch($sformatf("result beat col=%0d row=%0d side=%0d with no map pending",
				got.col, got.row, got.side));
		end else begin
			want = expected_squares.pop_front();
			checked++;
			if (got.col !== want.col)
				report_mismatch($sformatf("square_col %0d, expected %0d", got.col, want.col));
			if (got.row !== want.row)
				report_mismatch($sformatf("square_row %0d, expected %0d", got.row, want.row));
			if (got.side !== want.side)
				report_mismatch($sformatf("square_side %0d, expected %0d", got.side, want.side));
			if (got.overflow !== want.overflow)
				report_mismatch($sformatf("overflow %0b, expected %0b",
					got.overflow, want.overflow));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_char_q = EMPTY_CHAR_RESET;
			clear_scan();
			expected_squares.delete();
		end else begin
			if (cfg_we)
				empty_char_q = cfg_wdata;
			if (m_tvalid && m_tready)
				compare_result();
			if (s_tvalid && s_tready)
				fold_cell(s_tdata, s_tuser, s_tlast);
		end
		pending         <= expected_squares.size();
		fail_count      <= errors;
		squares_checked <= checked;
	end

endmodule

@@ sim/tb_largest_empty_square.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_largest_empty_square: testbench of the largest empty square finder
// Streams directed and random maps through the block under several empty
// characters and random back-pressure; les_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_largest_empty_square;
	import les_pkg::*;

	localparam int MAX_W      = 1024;
	localparam int MAX_H      = 1024;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_CELLS_PER_PHASE = 180;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	int          fail_count;
	int          pending;
	int          squares_checked;

	logic [7:0]  empty_char = EMPTY_CHAR_RESET;
	bit          src_gaps    = 1'b0;
	bit          sink_stalls = 1'b0;
	int          stall_left  = 0;
	int          idle_cycles = 0;
	int          cells_sent  = 0;
	int          maps_sent   = 0;
	int          settings    = 1;

	always #5 clk = ~clk;

	largest_empty_square #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	les_checker #(
		.MAX_W(MAX_W),
		.MAX_H(MAX_H)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.fail_count     (fail_count),
		.pending        (pending),
		.squares_checked(squares_checked)
	);

	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= pick_gap(1'b1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
				$display("FAIL largest_empty_square");
				$finish;
			end
		end
	end

	task automatic push_cell(input logic [7:0] cell_byte, input logic eor, input logic eom);
		int gap;
		gap = pick_gap(src_gaps);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cell_byte;
		s_tuser  <= eor;
		s_tlast  <= eom;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		cells_sent++;
		if (eom)
			maps_sent++;
	endtask

	task automatic wait_drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_empty_char(input logic [7:0] value);
		s_tvalid <= 1'b0;
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		empty_char  = value;
		settings++;
	endtask

	// Rows are separated by '|'; bare_end drops the end-of-row mark on the last cell.
	task automatic send_grid(input string g, input bit bare_end);
		logic eor;
		logic eom;
		for (int i = 0; i < g.len(); i++) begin
			if (g[i] != "|") begin
				eom = (i + 1 == g.len());
				eor = eom || g[i + 1] == "|";
				if (eom && bare_end)
					eor = 1'b0;
				push_cell(g[i], eor, eom);
			end
		end
	endtask

	function automatic logic [7:0] obstacle_byte();
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		if (v == empty_char)
			v[$urandom_range(0, 7)] = ~v[$urandom_range(0, 7)] ^ 1'b0;
		if (v == empty_char)
			v = ~empty_char;
		return v;
	endfunction

	task automatic send_random_map();
		int  rows;
		int  base_w;
		int  w;
		int  density;
		bit  ragged;
		bit  bare_end;
		logic eor;
		logic eom;
		logic [7:0] cell_byte;
		if ($urandom_range(0, 14) == 0) begin
			rows   = $urandom_range(10, 16);
			base_w = $urandom_range(10, 16);
		end else begin
			rows   = $urandom_range(1, 8);
			base_w = $urandom_range(1, 9);
		end
		ragged   = ($urandom_range(0, 4) == 0);
		bare_end = $urandom_range(0, 1);
		density  = $urandom_range(40, 97);
		for (int r = 0; r < rows; r++) begin
			w = ragged ? $urandom_range(1, base_w + 3) : base_w;
			for (int c = 0; c < w; c++) begin
				cell_byte = ($urandom_range(0, 99) < density) ? empty_char : obstacle_byte();
				eom  = (r == rows - 1) && (c == w - 1);
				eor  = (c == w - 1) && !(eom && bare_end);
				push_cell(cell_byte, eor, eom);
			end
		end
	endtask

	task automatic random_phase();
		int goal;
		goal = cells_sent + RANDOM_CELLS_PER_PHASE;
		while (cells_sent < goal)
			send_random_map();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		send_grid(".", 1'b0);
		send_grid("o", 1'b1);
		send_grid("..o..|..o..", 1'b0);
		send_grid("....|.|....", 1'b1);
		send_grid("...|...|...", 1'b0);

		write_empty_char(8'h00);
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		random_phase();

		write_empty_char(8'hFF);
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		random_phase();

		write_empty_char(8'($urandom_range(0, 255)));
		src_gaps    = 1'b0;
		sink_stalls = 1'b1;
		random_phase();

		write_empty_char(EMPTY_CHAR_RESET);
		src_gaps    = 1'b1;
		sink_stalls = 1'b0;
		random_phase();

		s_tvalid <= 1'b0;
		wait_drain();
		repeat (10) @(posedge clk);

		$display("Sent %0d cell beats in %0d maps under %0d empty characters.",
			cells_sent, maps_sent, settings);
		$display("Checked %0d result beats over directed, ragged and random maps.",
			squares_checked);
		if (fail_count == 0 && pending == 0)
			$display("PASS largest_empty_square");
		else
			$display("FAIL largest_empty_square");
		$finish;
	end

endmodule
